// ----- src/pfla_pkg.sv -----
// ----------------------------------------------------------------------------
// pfla_pkg: shared types and constants for the page free list allocator
// Command and status codes, stream field widths, and the control and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfla_pkg;

  // Input command codes (travel on s_tuser)
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STS_OK          = 2'd0;
  localparam logic [1:0] STS_NO_FREE     = 2'd1;
  localparam logic [1:0] STS_NONE_IN_USE = 2'd2;

  // Stream field widths
  localparam int PAGE_W    = 8;
  localparam int ID_W      = 32;
  localparam int STATUS_W  = 2;
  localparam int INUSE_W   = 9;
  localparam int TOTAL_W   = 32;
  localparam int S_TDATA_W = 8;
  localparam int OUT_BITS  = PAGE_W + ID_W + STATUS_W + INUSE_W + 2 * TOTAL_W;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W = M_TDATA_W - OUT_BITS;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted input transfer
    logic build_step;  // write one link entry of the ascending list
    logic exec;        // perform the latched command and load the result
  } pfla_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic built;       // free list is valid
    logic build_last;  // rebuild sweep is at the final entry
    logic out_free;    // result register can take a new result this cycle
  } pfla_sts_t;

endpackage

// ----- src/pfla_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfla_ctrl: allocator sequencer
// Accepts one command at a time, runs the link memory rebuild sweep when an
// allocate finds the pool discarded, then fires the command into the datapath.
// ----------------------------------------------------------------------------
module pfla_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  output pfla_pkg::pfla_cmd_t cmd,
  input  pfla_pkg::pfla_sts_t sts
);
  import pfla_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BUILD = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd.capture    = 1'b0;
    cmd.build_step = 1'b0;
    cmd.exec       = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          if (in_command == CMD_ALLOC && !sts.built) begin
            state_next = ST_BUILD;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_BUILD: begin
        cmd.build_step = 1'b1;
        if (sts.build_last) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold here while the previous result is still waiting downstream
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/pfla_dpath.sv -----
// ----------------------------------------------------------------------------
// pfla_dpath: free list datapath
// Link memory (next index plus end bit per page), head pointer, usage and
// grant counters, rebuild sweep counter and the result register.
// ----------------------------------------------------------------------------
module pfla_dpath #(
  parameter int PAGE_COUNT = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pfla_pkg::pfla_cmd_t            cmd,
  output pfla_pkg::pfla_sts_t            sts,
  input  logic                           in_command,
  input  logic [pfla_pkg::PAGE_W-1:0]    in_page,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pfla_pkg::M_TDATA_W-1:0] m_tdata
);
  import pfla_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);      // page index width
  localparam int CW = $clog2(PAGE_COUNT + 1);  // page count width

  // link memory: {end, next}
  logic [PW:0]         mem [PAGE_COUNT];
  logic [PW:0]         rdata;
  logic                mem_we;
  logic [PW-1:0]       mem_wa;
  logic [PW:0]         mem_wd;

  logic                cmd_r;
  logic [PAGE_W-1:0]   page_r;

  logic [PW-1:0]       head;
  logic                head_valid;
  logic                built;
  logic [CW-1:0]       in_use;
  logic [TOTAL_W-1:0]  req_total;
  logic [TOTAL_W-1:0]  freed_total;
  logic [ID_W-1:0]     next_id;
  logic [PW-1:0]       build_cnt;
  logic                build_last;

  logic                is_alloc;
  logic                alloc_ok;
  logic                free_ok;
  logic                page_in_pool;
  logic [CW-1:0]       in_use_dec;
  logic [CW-1:0]       in_use_after;
  logic [TOTAL_W-1:0]  req_after;
  logic [TOTAL_W-1:0]  freed_after;

  logic [PAGE_W-1:0]   o_page;
  logic [ID_W-1:0]     o_id;
  logic [STATUS_W-1:0] o_status;
  logic [INUSE_W-1:0]  o_in_use;
  logic [TOTAL_W-1:0]  o_req;
  logic [TOTAL_W-1:0]  o_freed;

  assign build_last   = (build_cnt == PW'(PAGE_COUNT - 1));
  assign is_alloc     = (cmd_r == CMD_ALLOC);
  assign alloc_ok     = head_valid && (in_use != CW'(PAGE_COUNT));
  assign free_ok      = (in_use != '0);
  assign page_in_pool = (32'(page_r) < 32'(PAGE_COUNT));
  assign in_use_dec   = in_use - 1'b1;

  always_comb begin
    in_use_after = in_use;
    req_after    = req_total;
    freed_after  = freed_total;
    if (is_alloc && alloc_ok) begin
      in_use_after = in_use + 1'b1;
      req_after    = req_total + 1'b1;
    end else if (!is_alloc && free_ok) begin
      in_use_after = in_use_dec;
      freed_after  = freed_total + 1'b1;
    end
  end

  // single write port: rebuild sweep or push of a freed page
  assign mem_we = cmd.build_step ||
                  (cmd.exec && !is_alloc && free_ok && page_in_pool);
  assign mem_wa = cmd.build_step ? build_cnt : PW'(page_r);
  assign mem_wd = cmd.build_step
                ? {build_last, (build_last ? {PW{1'b0}} : PW'(build_cnt + 1'b1))}
                : {!head_valid, head};

  // read tracks the head every cycle; data is ready the cycle after accept
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      page_r <= in_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      head_valid  <= 1'b0;
      built       <= 1'b0;
      in_use      <= '0;
      req_total   <= '0;
      freed_total <= '0;
      next_id     <= '0;
      build_cnt   <= '0;
    end else begin
      if (cmd.build_step) begin
        build_cnt <= build_last ? '0 : build_cnt + 1'b1;
        if (build_last) begin
          built      <= 1'b1;
          head       <= '0;
          head_valid <= 1'b1;
        end
      end
      if (cmd.exec) begin
        in_use      <= in_use_after;
        req_total   <= req_after;
        freed_total <= freed_after;
        if (is_alloc) begin
          if (alloc_ok) begin
            next_id    <= next_id + 1'b1;
            head       <= rdata[PW-1:0];
            head_valid <= !rdata[PW];
          end
        end else if (free_ok) begin
          if (in_use_dec == '0) begin
            // last page back: pool is discarded
            built      <= 1'b0;
            head_valid <= 1'b0;
            head       <= '0;
          end else if (page_in_pool) begin
            head       <= PW'(page_r);
            head_valid <= 1'b1;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      o_page   <= (is_alloc && alloc_ok) ? PAGE_W'(head) : '0;
      o_id     <= (is_alloc && alloc_ok) ? next_id : '0;
      o_status <= is_alloc ? (alloc_ok ? STS_OK : STS_NO_FREE)
                           : (free_ok ? STS_OK : STS_NONE_IN_USE);
      o_in_use <= INUSE_W'(in_use_after);
      o_req    <= req_after;
      o_freed  <= freed_after;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, o_freed, o_req, o_in_use, o_status, o_id, o_page};

  assign sts.built      = built;
  assign sts.build_last = build_last;
  assign sts.out_free   = !m_tvalid || m_tready;

`ifndef ASSERT_OFF
  a_exec_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending result");

  a_build_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.build_step && build_last) |=> (built && head_valid && head == '0))
    else $error("rebuild did not leave a full list at page zero");

  a_unbuilt_empty: assert property (@(posedge clk) disable iff (rst)
    !built |-> !head_valid)
    else $error("list head valid while pool is discarded");

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && !is_alloc && free_ok) |=> (in_use == $past(in_use) - 1'b1))
    else $error("successful free did not drop the in-use count");
`endif

endmodule

// ----- src/page_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// page_free_list_allocator: LIFO free list page allocator
// Pops pages on allocate, pushes them back on free, and rebuilds the list in
// ascending order on the first allocate after reset or after the pool empties.
//
//   channel  dir  tvalid/tready  payload
//   s_*      in   s_tvalid/rdy   s_tuser: command; s_tdata: page_index
//   m_*      out  m_tvalid/rdy   m_tdata: granted_page .. freed_total
//
// The result register loads in the execute state that follows the accepting
// idle state; a new command is taken only once the previous one has executed.
// The first allocate after reset or after the last page is freed first runs
// the rebuild sweep: the link memory write port sweeps every entry once.
// Reset clears control and counters; the link memory is rebuilt, not reset.
// A result waiting on m_tready holds only the next command's execute state.
// ----------------------------------------------------------------------------
module page_free_list_allocator #(
  parameter int PAGE_COUNT = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // page_index[7:0]
  input  logic [pfla_pkg::S_TDATA_W-1:0] s_tdata,
  // command[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // granted_page[7:0], grant_id[39:8], status[41:40], pages_in_use[50:42],
  // requested_total[82:51], freed_total[114:83], zero pad[119:115]
  output logic [pfla_pkg::M_TDATA_W-1:0] m_tdata
);
  import pfla_pkg::*;

  pfla_cmd_t cmd;
  pfla_sts_t sts;

  pfla_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tuser),
    .in_ready   (s_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pfla_dpath #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (s_tuser),
    .in_page    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ----- verif/page_free_list_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_free_list_allocator_tb: self-checking bench for the page allocator
// A directed table covers reset order, LIFO reuse, stray frees and the
// none-in-use error. Random fill, drain and mixed phases follow, with held
// pages freed back, full pool and empty pool hit. Results are checked against a
// behavioral free-list predictor; typed table rows fix status, page and in-use.
// ----------------------------------------------------------------------------
module page_free_list_allocator_tb;
  import pfla_pkg::*;

  localparam int PAGE_COUNT   = 256;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int IDLE_PCT     = 7;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [TOTAL_W-1:0]   freed_total;
    logic [TOTAL_W-1:0]   requested_total;
    logic [INUSE_W-1:0]   pages_in_use;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      grant_id;
    logic [PAGE_W-1:0]    granted_page;
  } grant_result_t;

  typedef struct packed {
    logic                cmd;
    logic [PAGE_W-1:0]   page;
    logic                typed;     // expected fields below are filled in
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   granted;
    logic [INUSE_W-1:0]  in_use;
  } stim_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  page_free_list_allocator #(.PAGE_COUNT(PAGE_COUNT)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // free-list shadow state
  logic [PAGE_W-1:0]  link_next [PAGE_COUNT];
  logic               link_last [PAGE_COUNT];
  logic [PAGE_W-1:0]  head_idx;
  logic               head_ok;
  logic               pool_ready;
  logic [INUSE_W-1:0] in_use;
  logic [TOTAL_W-1:0] alloc_total;
  logic [TOTAL_W-1:0] free_total;
  logic [ID_W-1:0]    id_next;

  grant_result_t     pending_results [$];
  logic [PAGE_W-1:0] held_pages [$];
  int items_sent;
  int mismatches;
  int cycles;

  stim_row_t directed_rows [25] = '{
    '{CMD_FREE,  8'd0,   1'b1, STS_NONE_IN_USE, 8'd0,   9'd0},
    '{CMD_FREE,  8'd255, 1'b1, STS_NONE_IN_USE, 8'd0,   9'd0},
    '{CMD_ALLOC, 8'hff,  1'b1, STS_OK,          8'd0,   9'd1},
    '{CMD_ALLOC, 8'd0,   1'b1, STS_OK,          8'd1,   9'd2},
    '{CMD_ALLOC, 8'd0,   1'b1, STS_OK,          8'd2,   9'd3},
    '{CMD_FREE,  8'd1,   1'b1, STS_OK,          8'd0,   9'd2},
    '{CMD_ALLOC, 8'd0,   1'b1, STS_OK,          8'd1,   9'd3},
    '{CMD_FREE,  8'd2,   1'b1, STS_OK,          8'd0,   9'd2},
    '{CMD_FREE,  8'd0,   1'b1, STS_OK,          8'd0,   9'd1},
    '{CMD_ALLOC, 8'h55,  1'b1, STS_OK,          8'd0,   9'd2},
    '{CMD_ALLOC, 8'haa,  1'b1, STS_OK,          8'd2,   9'd3},
    '{CMD_ALLOC, 8'd0,   1'b1, STS_OK,          8'd3,   9'd4},
    // stray free of a page never handed out goes on the head
    '{CMD_FREE,  8'd255, 1'b1, STS_OK,          8'd0,   9'd3},
    '{CMD_ALLOC, 8'd0,   1'b1, STS_OK,          8'd255, 9'd4},
    '{CMD_ALLOC, 8'd0,   1'b1, STS_OK,          8'd4,   9'd5},
    '{CMD_FREE,  8'd4,   1'b0, STS_OK,          8'd0,   9'd0},
    '{CMD_FREE,  8'd3,   1'b0, STS_OK,          8'd0,   9'd0},
    '{CMD_FREE,  8'd2,   1'b0, STS_OK,          8'd0,   9'd0},
    '{CMD_FREE,  8'd1,   1'b0, STS_OK,          8'd0,   9'd0},
    '{CMD_FREE,  8'd0,   1'b1, STS_OK,          8'd0,   9'd0},
    '{CMD_FREE,  8'd7,   1'b1, STS_NONE_IN_USE, 8'd0,   9'd0},
    // pool discarded: next allocate starts again from page 0
    '{CMD_ALLOC, 8'd0,   1'b1, STS_OK,          8'd0,   9'd1},
    '{CMD_FREE,  8'd0,   1'b1, STS_OK,          8'd0,   9'd0},
    '{CMD_ALLOC, 8'h80,  1'b1, STS_OK,          8'd0,   9'd1},
    '{CMD_FREE,  8'h80,  1'b0, STS_OK,          8'd0,   9'd0}
  };

  function automatic bit calm_window();
    return items_sent >= 700 && items_sent < 950;
  endfunction

  task automatic step_allocator(input logic cmd, input logic [PAGE_W-1:0] page,
                                output grant_result_t r);
    logic [PAGE_W-1:0] h;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (!pool_ready) begin
        for (int i = 0; i < PAGE_COUNT; i++) begin
          link_next[i] = (i + 1 < PAGE_COUNT) ? PAGE_W'(i + 1) : '0;
          link_last[i] = (i + 1 >= PAGE_COUNT);
        end
        head_idx   = '0;
        head_ok    = 1'b1;
        pool_ready = 1'b1;
      end
      if (!head_ok || int'(in_use) >= PAGE_COUNT) begin
        r.status = STS_NO_FREE;
      end else begin
        h              = head_idx;
        r.granted_page = h;
        r.grant_id     = id_next;
        id_next        = id_next + 1'b1;
        alloc_total    = alloc_total + 1'b1;
        in_use         = in_use + 1'b1;
        head_ok        = !link_last[h];
        head_idx       = link_next[h];
      end
    end else begin
      if (in_use == 0) begin
        r.status = STS_NONE_IN_USE;
      end else begin
        free_total      = free_total + 1'b1;
        in_use          = in_use - 1'b1;
        link_next[page] = head_idx;
        link_last[page] = !head_ok;
        head_idx        = page;
        head_ok         = 1'b1;
        if (in_use == 0) begin
          pool_ready = 1'b0;
          head_ok    = 1'b0;
          head_idx   = '0;
        end
      end
    end
    r.pages_in_use    = in_use;
    r.requested_total = alloc_total;
    r.freed_total     = free_total;
  endtask

  task automatic report_mismatch(input string what, input grant_result_t e,
                                 input grant_result_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at cycle %0d", what, cycles);
      $display("  exp page %0d id %0d sts %0d use %0d req %0d freed %0d",
               e.granted_page, e.grant_id, e.status, e.pages_in_use,
               e.requested_total, e.freed_total);
      $display("  got page %0d id %0d sts %0d use %0d req %0d freed %0d",
               g.granted_page, g.grant_id, g.status, g.pages_in_use,
               g.requested_total, g.freed_total);
    end
  endtask

  // Drives one command, waits for the transfer, then records the expectation.
  task automatic issue_cmd(input logic cmd, input logic [PAGE_W-1:0] page,
                           input stim_row_t row);
    grant_result_t r;
    int idx;
    @(negedge clk);
    while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= page;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    step_allocator(cmd, page, r);
    if (row.typed) begin
      r.status       = row.status;
      r.granted_page = row.granted;
      r.pages_in_use = row.in_use;
    end
    pending_results.push_back(r);
    // keep track of pages out on loan so random frees are mostly legal
    if (r.status == STS_OK) begin
      if (cmd == CMD_ALLOC) begin
        held_pages.push_back(r.granted_page);
      end else begin
        idx = -1;
        foreach (held_pages[i]) if (idx < 0 && held_pages[i] == page) idx = i;
        if (idx >= 0) held_pages.delete(idx);
      end
      if (r.pages_in_use == 0) held_pages.delete();
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("page_free_list_allocator_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst) m_tready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    grant_result_t got;
    grant_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = grant_result_t'(m_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.granted_page !== exp_r.granted_page || got.grant_id !== exp_r.grant_id ||
            got.status !== exp_r.status || got.pages_in_use !== exp_r.pages_in_use ||
            got.requested_total !== exp_r.requested_total ||
            got.freed_total !== exp_r.freed_total)
          report_mismatch("field", exp_r, got);
      end
    end
  end

  initial begin
    logic              cmd;
    logic [PAGE_W-1:0] page;
    int phase_no;
    int alloc_pct;
    int phase_len;
    int random_sent;
    int kind;

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_ALLOC;
    m_tready   = 1'b0;
    items_sent = 0;
    mismatches = 0;
    cycles     = 0;
    head_idx   = '0;
    head_ok    = 1'b0;
    pool_ready = 1'b0;
    in_use     = '0;
    alloc_total = '0;
    free_total = '0;
    id_next    = '0;
    foreach (link_next[i]) begin
      link_next[i] = '0;
      link_last[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].cmd, directed_rows[i].page, directed_rows[i]);

    // First two phases walk the pool to full and back to empty, both errors
    // included; later phases pick fill, drain, mixed or shallow at random.
    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase_no == 0) begin
        alloc_pct = 100;
        phase_len = PAGE_COUNT + 4;
      end else if (phase_no == 1) begin
        alloc_pct = 0;
        phase_len = PAGE_COUNT + 4;
      end else begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin
            alloc_pct = 90;
            phase_len = $urandom_range(200, 320);
          end
          1: begin
            alloc_pct = 10;
            phase_len = $urandom_range(200, 320);
          end
          2: begin
            alloc_pct = 50;
            phase_len = $urandom_range(40, 120);
          end
          default: begin
            alloc_pct = 40;
            phase_len = $urandom_range(40, 100);
          end
        endcase
      end
      for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
        cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        if (cmd == CMD_FREE && held_pages.size() != 0 && $urandom_range(0, 9) != 0)
          page = held_pages[$urandom_range(0, held_pages.size() - 1)];
        else
          page = PAGE_W'($urandom_range(0, 255));
        issue_cmd(cmd, page, '0);
        random_sent++;
      end
      if (phase_no == 0 || $urandom_range(0, 2) == 0) drain_results();
      phase_no++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("page_free_list_allocator_tb: clean");
    end else begin
      $display("page_free_list_allocator_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pfla_pkg.sv
src/pfla_ctrl.sv
src/pfla_dpath.sv
src/page_free_list_allocator.sv
verif/page_free_list_allocator_tb.sv
